>>> hw/rtl/wnrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wnrs_pkg
// Shared types, constants and fill-rule functions for the winding number
// region selector.
// ----------------------------------------------------------------------------
package wnrs_pkg;

  localparam int NUM_GROUPS  = 256;
  localparam int COUNT_WIDTH = 16;
  localparam int TOTAL_WIDTH = 24;
  localparam int GID_W       = 16;
  localparam int GIU_W       = 9;
  localparam int IDX_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int INSIDE_W    = $clog2(NUM_GROUPS + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  typedef logic signed [COUNT_WIDTH-1:0] count_t;
  typedef logic signed [TOTAL_WIDTH-1:0] total_t;
  typedef logic [INSIDE_W-1:0]           inside_t;

  localparam count_t CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam count_t CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam total_t TOT_MAX = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
  localparam total_t TOT_MIN = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};
  localparam count_t CNT_ONE = count_t'(1);
  localparam total_t TOT_ONE = total_t'(1);
  localparam inside_t INSIDE_FULL = inside_t'(NUM_GROUPS);
  localparam inside_t INSIDE_ONE  = inside_t'(1);

  localparam logic [1:0] KIND_CLEAR    = 2'd0;
  localparam logic [1:0] KIND_ENTER    = 2'd1;
  localparam logic [1:0] KIND_EXIT     = 2'd2;
  localparam logic [1:0] KIND_BOUNDARY = 2'd3;

  localparam logic [1:0] GR_PARITY   = 2'd0;
  localparam logic [1:0] GR_POSITIVE = 2'd1;
  localparam logic [1:0] GR_NONZERO  = 2'd2;
  localparam logic [1:0] GR_NEGATIVE = 2'd3;

  localparam logic [2:0] CR_UNION        = 3'd0;
  localparam logic [2:0] CR_GROUP_PARITY = 3'd1;
  localparam logic [2:0] CR_SUM_PARITY   = 3'd2;
  localparam logic [2:0] CR_SUM_POSITIVE = 3'd3;
  localparam logic [2:0] CR_SUM_NONZERO  = 3'd4;
  localparam logic [2:0] CR_SUM_NEGATIVE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_RULE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_RULE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_RESULT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUPS_IN_USE = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  function automatic logic group_is_inside(input count_t z, input logic [1:0] rule);
    logic r;
    unique case (rule)
      GR_PARITY:   r = z[0];
      GR_POSITIVE: r = !z[COUNT_WIDTH-1] && (z != '0);
      GR_NONZERO:  r = (z != '0);
      GR_NEGATIVE: r = z[COUNT_WIDTH-1];
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic combined_inside(input inside_t gi, input total_t tc,
                                           input logic [2:0] rule, input logic inv);
    logic r;
    case (rule)
      CR_UNION:        r = (gi != '0);
      CR_GROUP_PARITY: r = gi[0];
      CR_SUM_PARITY:   r = tc[0];
      CR_SUM_POSITIVE: r = !tc[TOTAL_WIDTH-1] && (tc != '0);
      CR_SUM_NONZERO:  r = (tc != '0);
      CR_SUM_NEGATIVE: r = tc[TOTAL_WIDTH-1];
      default:         r = 1'b0;
    endcase
    return r ^ inv;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/winding_number_region_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// winding_number_region_selector
// Tracks per-group winding counts over face-crossing events and selects
// faces that are entered while inside under the configured fill rules.
// ----------------------------------------------------------------------------
// Each event has an accept cycle and an update cycle: the accept cycle
// reads the group count from the count memory, and the following cycle
// (busy high) updates the count, writes it back and updates the inside and
// total counters. The result strobe (done) rises in the cycle after that
// and lasts one cycle; the receiver cannot stall it. A new start is taken
// in that same cycle but not while busy. A clear event empties all
// counts at once through per-entry valid bits; there is no clearing pass.
// Configuration writes are always ready and must be issued while idle.
// ----------------------------------------------------------------------------
module winding_number_region_selector (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [1:0]                       kind,
  input  wire  [wnrs_pkg::GID_W-1:0]       group_id,
  input  wire                              group_known,
  input  wire                              edge_active,
  input  wire                              node_present,
  output logic                             done,
  output logic                             mark,
  output logic                             inside_res,
  output logic                             group_ignored,
  output logic                             saturated,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [wnrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [wnrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wnrs_pkg::*;

  state_t state, state_next;

  logic [1:0]       group_rule;
  logic [2:0]       combine_rule;
  logic             invert_result;
  logic [GIU_W-1:0] groups_in_use;

  logic [1:0]       kind_q;
  logic [GID_W-1:0] gid_q;
  logic             known_q;
  logic             active_q;
  logic             present_q;

  logic [NUM_GROUPS-1:0] entry_valid;
  inside_t               groups_inside;
  total_t                total_count;

  logic             accept;
  logic [IDX_W-1:0] idx;
  count_t           ram_rdata;
  count_t           z0;
  count_t           z1;
  logic             counting;
  logic             in_range;
  logic             do_update;
  logic             enter_q;
  logic             cnt_sat;
  logic             b0;
  logic             b1;
  logic             gi_sat;
  logic             tc_sat;
  inside_t          gi_next;
  total_t           tc_next;
  logic             write_en;
  logic             clear_now;
  logic             inside_now;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign idx       = gid_q[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // hold the event fields for the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= kind;
      gid_q     <= group_id;
      known_q   <= group_known;
      active_q  <= edge_active;
      present_q <= node_present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_rule    <= '0;
      combine_rule  <= '0;
      invert_result <= 1'b0;
      groups_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GROUP_RULE:    group_rule    <= cfg_data[1:0];
        REG_COMBINE_RULE:  combine_rule  <= cfg_data[2:0];
        REG_INVERT_RESULT: invert_result <= cfg_data[0];
        REG_GROUPS_IN_USE: groups_in_use <= cfg_data[GIU_W-1:0];
        default: ;
      endcase
    end
  end

  wnrs_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_GROUPS)
  ) u_counts (
    .clk   (clk),
    .we    (write_en),
    .waddr (idx),
    .wdata (z1),
    .raddr (group_id[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    clear_now = busy && (kind_q == KIND_CLEAR);
    enter_q   = (kind_q == KIND_ENTER);
    counting  = (kind_q == KIND_ENTER || kind_q == KIND_EXIT) && known_q && active_q;
    in_range  = (gid_q < {{(GID_W-GIU_W){1'b0}}, groups_in_use})
             && (32'(gid_q) < 32'(NUM_GROUPS));
    z0        = entry_valid[idx] ? ram_rdata : '0;
    z1        = enter_q ? z0 + CNT_ONE : z0 - CNT_ONE;
    cnt_sat   = enter_q ? (z0 == CNT_MAX) : (z0 == CNT_MIN);
    do_update = busy && counting && in_range && !cnt_sat;
    write_en  = do_update;

    b0 = group_is_inside(z0, group_rule);
    b1 = group_is_inside(z1, group_rule);

    gi_next = groups_inside;
    gi_sat  = 1'b0;
    if (b1 && !b0) begin
      if (groups_inside >= INSIDE_FULL) begin
        gi_next = INSIDE_FULL;
        gi_sat  = 1'b1;
      end else begin
        gi_next = groups_inside + INSIDE_ONE;
      end
    end else if (b0 && !b1) begin
      if (groups_inside == '0) begin
        gi_sat = 1'b1;
      end else begin
        gi_next = groups_inside - INSIDE_ONE;
      end
    end

    tc_sat  = enter_q ? (total_count == TOT_MAX) : (total_count == TOT_MIN);
    tc_next = total_count;
    if (!tc_sat) begin
      tc_next = enter_q ? total_count + TOT_ONE : total_count - TOT_ONE;
    end

    if (clear_now) begin
      inside_now = combined_inside('0, '0, combine_rule, invert_result);
    end else if (do_update) begin
      inside_now = combined_inside(gi_next, tc_next, combine_rule, invert_result);
    end else begin
      inside_now = combined_inside(groups_inside, total_count, combine_rule,
                                   invert_result);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= '0;
      groups_inside <= '0;
      total_count   <= '0;
    end else if (clear_now) begin
      entry_valid   <= '0;
      groups_inside <= '0;
      total_count   <= '0;
    end else if (do_update) begin
      entry_valid[idx] <= 1'b1;
      groups_inside    <= gi_next;
      total_count      <= tc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mark          <= enter_q && present_q && inside_now;
      inside_res    <= inside_now;
      group_ignored <= counting && !in_range;
      saturated     <= counting && in_range && (cnt_sat || gi_sat || tc_sat);
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("result strobe missing after update cycle");

  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted event did not enter update cycle");

  a_mark_inside: assert property (@(posedge clk) disable iff (rst)
    done && mark |-> inside_res)
    else $error("mark without inside decision");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(group_ignored && saturated))
    else $error("ignored event reported as saturated");

  a_inside_bound: assert property (@(posedge clk) disable iff (rst)
    groups_inside <= INSIDE_FULL)
    else $error("inside count beyond group count");

endmodule
`default_nettype wire

>>> hw/rtl/wnrs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wnrs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module wnrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire                           clk,
  input  wire                           we,
  input  wire  [$clog2(DEPTH)-1:0]      waddr,
  input  wire  [WIDTH-1:0]              wdata,
  input  wire  [$clog2(DEPTH)-1:0]      raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> tb/sv/winding_number_region_selector_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// winding_number_region_selector_tb
// Self-checking bench for the winding number region selector. A scoreboard
// class keeps its own copy of the per-group counts, the inside count, the
// crossing sum and the register settings. It predicts every result from the
// events the block accepts and checks each strobed result against the oldest
// prediction. Stimulus covers field extremes, ignored and out-of-range
// groups, the spare combine codes, inside-count saturation at both ends,
// and then random event streams under several register settings.
// ----------------------------------------------------------------------------
module winding_number_region_selector_tb;
  import wnrs_pkg::*;

  localparam logic [2:0] CR_SPARE_LO   = 3'd6;
  localparam logic [2:0] CR_SPARE_HI   = 3'd7;
  localparam int         RANDOM_PHASES = 8;
  localparam int         PHASE_EVENTS  = 59;

  typedef struct packed {
    logic mark;
    logic inside_res;
    logic ignored;
    logic sat;
  } verdict_t;

  class region_scoreboard;
    logic [1:0]       grp_rule;
    logic [2:0]       comb_rule;
    logic             invert;
    logic [GIU_W-1:0] giu;
    count_t           counts[NUM_GROUPS];
    int               inside_groups;
    int               crossing_sum;
    verdict_t         verdicts[$];
    int               errors;

    function new();
      grp_rule  = GR_PARITY;
      comb_rule = CR_UNION;
      invert    = 1'b0;
      giu       = '0;
      errors    = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (counts[i]) counts[i] = '0;
      inside_groups = 0;
      crossing_sum  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GROUP_RULE:    grp_rule  = val[1:0];
        REG_COMBINE_RULE:  comb_rule = val[2:0];
        REG_INVERT_RESULT: invert    = val[0];
        REG_GROUPS_IN_USE: giu       = val;
        default: ;
      endcase
    endfunction

    function int group_in(int z);
      case (grp_rule)
        GR_PARITY:   return int'(z[0]);
        GR_POSITIVE: return int'(z > 0);
        GR_NONZERO:  return int'(z != 0);
        default:     return int'(z < 0);
      endcase
    endfunction

    function logic region_in();
      logic r;
      case (comb_rule)
        CR_UNION:        r = inside_groups > 0;
        CR_GROUP_PARITY: r = inside_groups[0];
        CR_SUM_PARITY:   r = crossing_sum[0];
        CR_SUM_POSITIVE: r = crossing_sum > 0;
        CR_SUM_NONZERO:  r = crossing_sum != 0;
        CR_SUM_NEGATIVE: r = crossing_sum < 0;
        default:         r = 1'b0;
      endcase
      return r ^ invert;
    endfunction

    function void note_event(logic [1:0] k, logic [GID_W-1:0] gid, logic known,
                             logic active, logic present);
      verdict_t v;
      int       step;
      int       z0;
      int       z1;
      int       gi;
      int       tc;
      v = '0;
      if (k == KIND_CLEAR) begin
        clear_counts();
      end else if ((k == KIND_ENTER || k == KIND_EXIT) && known && active) begin
        if (gid >= giu || gid >= NUM_GROUPS) begin
          v.ignored = 1'b1;
        end else begin
          step = (k == KIND_ENTER) ? 1 : -1;
          z0   = int'(counts[gid]);
          z1   = z0 + step;
          if (z1 > int'(CNT_MAX) || z1 < int'(CNT_MIN)) begin
            v.sat = 1'b1;
          end else begin
            gi = inside_groups + group_in(z1) - group_in(z0);
            tc = crossing_sum + step;
            counts[gid] = count_t'(z1);
            if (gi < 0) begin
              gi    = 0;
              v.sat = 1'b1;
            end else if (gi > NUM_GROUPS) begin
              gi    = NUM_GROUPS;
              v.sat = 1'b1;
            end
            inside_groups = gi;
            if (tc > int'(TOT_MAX) || tc < int'(TOT_MIN)) v.sat = 1'b1;
            else crossing_sum = tc;
          end
        end
      end
      v.inside_res = region_in();
      v.mark       = (k == KIND_ENTER) && present && v.inside_res;
      verdicts.insert(verdicts.size(), v);
    endfunction

    function void check_result(logic m, logic ins, logic ign, logic s);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("result strobe with no event outstanding");
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (m !== v.mark) begin
        $error("mark: expected %0b, got %0b", v.mark, m);
        errors++;
      end
      if (ins !== v.inside_res) begin
        $error("inside_res: expected %0b, got %0b", v.inside_res, ins);
        errors++;
      end
      if (ign !== v.ignored) begin
        $error("group_ignored: expected %0b, got %0b", v.ignored, ign);
        errors++;
      end
      if (s !== v.sat) begin
        $error("saturated: expected %0b, got %0b", v.sat, s);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  start        = 1'b0;
  logic                  busy;
  logic [1:0]            kind         = KIND_BOUNDARY;
  logic [GID_W-1:0]      group_id     = '0;
  logic                  group_known  = 1'b0;
  logic                  edge_active  = 1'b0;
  logic                  node_present = 1'b0;
  logic                  done;
  logic                  mark;
  logic                  inside_res;
  logic                  group_ignored;
  logic                  saturated;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  region_scoreboard sb = new();
  bit               allow_idle = 1'b1;
  int unsigned      giu_choices[RANDOM_PHASES] = '{1, 256, 2, 16, 64, 255, 4, 256};

  winding_number_region_selector DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .group_id     (group_id),
    .group_known  (group_known),
    .edge_active  (edge_active),
    .node_present (node_present),
    .done         (done),
    .mark         (mark),
    .inside_res   (inside_res),
    .group_ignored(group_ignored),
    .saturated    (saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(mark, inside_res, group_ignored, saturated);
  end

  task automatic send_event(logic [1:0] k, logic [GID_W-1:0] gid, logic known,
                            logic active, logic present);
    if (allow_idle && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start        <= 1'b1;
    kind         <= k;
    group_id     <= gid;
    group_known  <= known;
    edge_active  <= active;
    node_present <= present;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_event(k, gid, known, active, present);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_config(logic [1:0] g, logic [2:0] c, logic inv,
                                logic [GIU_W-1:0] u);
    write_reg(REG_GROUP_RULE, CFG_DATA_W'(g));
    write_reg(REG_COMBINE_RULE, CFG_DATA_W'(c));
    write_reg(REG_INVERT_RESULT, CFG_DATA_W'(inv));
    write_reg(REG_GROUPS_IN_USE, u);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_event(int unsigned giu, bit grow);
    int unsigned      pick;
    int unsigned      near;
    logic [1:0]       k;
    logic [GID_W-1:0] gid;
    pick = $urandom_range(0, 99);
    if (pick < 3) k = KIND_CLEAR;
    else if (pick < 9) k = KIND_BOUNDARY;
    else k = ($urandom_range(0, 99) < (grow ? 65 : 35)) ? KIND_ENTER : KIND_EXIT;
    near = (giu < 8) ? giu : 8;
    pick = $urandom_range(0, 99);
    if (pick < 60) gid = GID_W'($urandom_range(0, near - 1));
    else if (pick < 80) gid = GID_W'($urandom_range(0, giu - 1));
    else if (pick < 90) gid = GID_W'($urandom_range(giu, 16'hFFFF));
    else gid = GID_W'($urandom);
    send_event(k, gid, $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
               $urandom_range(0, 6) != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // no group is in use after reset
    send_event(KIND_ENTER, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_event(KIND_EXIT, 16'h0001, 1'b1, 1'b1, 1'b1);
    drain();

    program_config(GR_PARITY, CR_UNION, 1'b0, 9'd256);
    send_event(KIND_ENTER, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_event(KIND_ENTER, 16'h00FF, 1'b1, 1'b1, 1'b0);
    send_event(KIND_EXIT, 16'h00FF, 1'b1, 1'b1, 1'b1);
    send_event(KIND_ENTER, 16'h0100, 1'b1, 1'b1, 1'b1);
    send_event(KIND_EXIT, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_event(KIND_ENTER, 16'hAAAA, 1'b1, 1'b1, 1'b1);
    send_event(KIND_ENTER, 16'h5555, 1'b1, 1'b1, 1'b1);
    send_event(KIND_ENTER, 16'h0005, 1'b0, 1'b1, 1'b1);
    send_event(KIND_EXIT, 16'h0005, 1'b1, 1'b0, 1'b1);
    send_event(KIND_BOUNDARY, 16'h5A5A, 1'b1, 1'b1, 1'b1);
    send_event(KIND_CLEAR, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_event(KIND_EXIT, 16'h0000, 1'b1, 1'b1, 1'b1);
    drain();

    program_config(GR_NONZERO, CR_SPARE_LO, 1'b1, 9'd256);
    send_event(KIND_ENTER, 16'h0003, 1'b1, 1'b1, 1'b1);
    drain();
    program_config(GR_NONZERO, CR_SPARE_HI, 1'b0, 9'd256);
    send_event(KIND_ENTER, 16'h0003, 1'b1, 1'b1, 1'b1);
    send_event(KIND_CLEAR, 16'h0000, 1'b0, 1'b0, 1'b0);
    drain();

    // inside count driven below zero by a rule change
    program_config(GR_NEGATIVE, CR_UNION, 1'b0, 9'd256);
    send_event(KIND_ENTER, 16'h0000, 1'b1, 1'b1, 1'b1);
    drain();
    program_config(GR_POSITIVE, CR_UNION, 1'b0, 9'd256);
    send_event(KIND_EXIT, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_event(KIND_CLEAR, 16'h0000, 1'b1, 1'b1, 1'b1);

    // inside count driven above the group total by a rule change
    for (int g = 0; g < NUM_GROUPS; g++) begin
      send_event(KIND_ENTER, GID_W'(g), 1'b1, 1'b1, 1'b1);
    end
    drain();
    program_config(GR_NEGATIVE, CR_GROUP_PARITY, 1'b0, 9'd256);
    send_event(KIND_EXIT, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_event(KIND_EXIT, 16'h0000, 1'b1, 1'b1, 1'b1);
    send_event(KIND_CLEAR, 16'h0000, 1'b1, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_config(2'(ph % 4), 3'(ph), 1'((ph >> 1) & 1), GIU_W'(giu_choices[ph]));
      allow_idle = (ph != 3 && ph != 4);
      repeat (PHASE_EVENTS) random_event(giu_choices[ph], ph[0]);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
